[rtl/tlc_pkg.sv]
`default_nettype none
package tlc_pkg;

  localparam int NumSocketsDef = 64;
  localparam int QueueDepthDef = 64;
  localparam int TimeBitsDef   = 32;

  localparam int SockBits  = 6;
  localparam int EventBits = 32;

  typedef enum logic [1:0] {
    REQ_REGISTER   = 2'd0,
    REQ_UNREGISTER = 2'd1,
    REQ_ADD        = 2'd2,
    REQ_TICK       = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    ST_DONE   = 3'd0,
    ST_FIRED  = 3'd1,
    ST_NONE   = 3'd2,
    ST_REJECT = 3'd3,
    ST_FULL   = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_SEXEC, S_ACHK, S_URD, S_UCMP, S_TTOP,
    S_TCHK, S_TLAST, S_DL, S_DR, S_DCMP, S_TNEXT, S_FIN
  } state_e;

endpackage
`default_nettype wire

[rtl/tlc_ram.sv]
`default_nettype none
module tlc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule
`default_nettype wire

[rtl/timer_heap_lazy_cancel.sv]
// channel  | direction | handshake                | payload
// in       | input     | in_valid_i, in_stall_o   | req_type, socket_id, event_ver, times
// out      | output    | out_valid_o, out_stall_i | status, fired_socket, fired_event
// one transaction in flight; register, unregister and a rejected add finish once the socket entry is handled
// an accepted add stores the entry at the end of the heap and sifts it up, comparing it with each parent
// a tick checks the top; while it is due, the tick pops it, moves the last entry to the root
// and sifts that down level by level, until a timer fires, the heap is empty or the top is not yet due
// after reset a clearing pass over the socket memory runs before the first transaction is taken
// the next transaction is taken while a result waits under out_stall_i
`default_nettype none
module timer_heap_lazy_cancel #(
  parameter int NUM_SOCKETS = tlc_pkg::NumSocketsDef,
  parameter int QUEUE_DEPTH = tlc_pkg::QueueDepthDef,
  parameter int TIME_BITS   = tlc_pkg::TimeBitsDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  req_type_i,
  input  wire logic [5:0]  socket_id_i,
  input  wire logic [31:0] event_ver_i,
  input  wire logic [31:0] expire_time_i,
  input  wire logic [31:0] current_time_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [2:0]       status_o,
  output logic [5:0]       fired_socket_o,
  output logic [31:0]      fired_event_o
);
  import tlc_pkg::*;

  localparam int SAW = $clog2(NUM_SOCKETS);
  localparam int HAW = $clog2(QUEUE_DEPTH);
  localparam int TW  = TIME_BITS;
  localparam int EW  = TW + SockBits + EventBits;
  localparam int SW  = 1 + EventBits;

  state_e state_q, state_d;
  req_e   req_q, req_d;
  status_e st_q, st_d;
  logic [SockBits-1:0]  sock_q, sock_d;
  logic [EventBits-1:0] ev_q, ev_d;
  logic [TW-1:0]        exp_q, exp_d, now_q, now_d;
  logic [EW-1:0]        cur_q, cur_d, top_q, top_d, lval_q, lval_d;
  logic [HAW-1:0]       idx_q, idx_d;
  logic [HAW:0]         cnt_q, cnt_d;
  logic                 rok_q, rok_d, fire_q, fire_d;
  logic [SAW-1:0]       clr_q, clr_d;
  logic                 ov_q, ov_d;
  status_e              ost_q, ost_d;
  logic [SockBits-1:0]  osock_q, osock_d;
  logic [EventBits-1:0] oev_q, oev_d;

  logic           hwe, hre, swe, sre;
  logic [HAW-1:0] hwaddr, hraddr;
  logic [EW-1:0]  hwdata, hrd;
  logic [SAW-1:0] swaddr, sraddr;
  logic [SW-1:0]  swdata, srd;

  logic           in_fire, out_free, in_rng, top_rng, clr_last;
  logic [HAW:0]   lpos;
  logic [HAW+1:0] rpos;
  logic           l_ok, r_ok, up_less, pick_l, pick_r, late;
  logic [EW-1:0]  best_lc;
  logic [HAW-1:0] parent;

  tlc_ram #(.WIDTH(EW), .DEPTH(QUEUE_DEPTH)) u_heap (
    .clk_i, .we_i(hwe), .waddr_i(hwaddr), .wdata_i(hwdata),
    .re_i(hre), .raddr_i(hraddr), .rdata_o(hrd)
  );

  tlc_ram #(.WIDTH(SW), .DEPTH(NUM_SOCKETS)) u_sock (
    .clk_i, .we_i(swe), .waddr_i(swaddr), .wdata_i(swdata),
    .re_i(sre), .raddr_i(sraddr), .rdata_o(srd)
  );

  assign in_stall_o = (state_q != S_IDLE);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign out_free   = !ov_q || !out_stall_i;
  assign in_rng     = 32'(sock_q) < 32'(NUM_SOCKETS);
  assign top_rng    = 32'(top_q[EventBits +: SockBits]) < 32'(NUM_SOCKETS);
  assign clr_last   = clr_q == SAW'(NUM_SOCKETS - 1);
  assign lpos       = {idx_q, 1'b1};
  assign rpos       = (HAW+2)'(lpos) + (HAW+2)'(1);
  assign l_ok       = (HAW+2)'(lpos) < (HAW+2)'(cnt_q);
  assign r_ok       = rpos < (HAW+2)'(cnt_q);
  assign parent     = HAW'((idx_q - HAW'(1)) >> 1);
  assign up_less    = cur_q < hrd;
  assign pick_l     = lval_q < cur_q;
  assign best_lc    = pick_l ? lval_q : cur_q;
  assign pick_r     = rok_q && (hrd < best_lc);
  assign late       = hrd[EW-1 -: TW] > now_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLR:   if (clr_last) state_d = S_IDLE;
      S_IDLE: begin
        if (in_fire) begin
          unique case (req_e'(req_type_i))
            REQ_REGISTER, REQ_UNREGISTER: state_d = S_SEXEC;
            REQ_ADD:                      state_d = S_ACHK;
            REQ_TICK:                     state_d = S_TTOP;
            default:                      state_d = S_TTOP;
          endcase
        end
      end
      S_SEXEC: state_d = S_FIN;
      S_ACHK: begin
        if (!in_rng || !srd[SW-1] || cnt_q == (HAW+1)'(QUEUE_DEPTH)) state_d = S_FIN;
        else state_d = S_URD;
      end
      S_URD:   state_d = (idx_q == '0) ? S_FIN : S_UCMP;
      S_UCMP:  state_d = up_less ? S_URD : S_FIN;
      S_TTOP:  state_d = (cnt_q == '0) ? S_FIN : S_TCHK;
      S_TCHK:  state_d = late ? S_FIN : S_TLAST;
      S_TLAST: state_d = (cnt_q == '0) ? S_TNEXT : S_DL;
      S_DL:    state_d = l_ok ? S_DR : S_TNEXT;
      S_DR:    state_d = S_DCMP;
      S_DCMP:  state_d = (pick_l || pick_r) ? S_DL : S_TNEXT;
      S_TNEXT: state_d = fire_q ? S_FIN : S_TTOP;
      S_FIN:   if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    req_d = req_q; st_d = st_q; sock_d = sock_q; ev_d = ev_q;
    exp_d = exp_q; now_d = now_q; cur_d = cur_q; top_d = top_q;
    lval_d = lval_q; idx_d = idx_q; cnt_d = cnt_q; rok_d = rok_q;
    fire_d = fire_q; clr_d = clr_q;
    ov_d = ov_q && out_stall_i; ost_d = ost_q; osock_d = osock_q; oev_d = oev_q;
    hwe = 1'b0; hwaddr = idx_q; hwdata = cur_q; hre = 1'b0; hraddr = '0;
    swe = 1'b0; swaddr = SAW'(sock_q); swdata = '0;
    sre = 1'b0; sraddr = SAW'(sock_q);
    unique case (state_q)
      S_CLR: begin
        swe    = 1'b1;
        swaddr = clr_q;
        clr_d  = clr_q + SAW'(1);
      end
      S_IDLE: begin
        if (in_fire) begin
          req_d  = req_e'(req_type_i);
          sock_d = socket_id_i;
          ev_d   = event_ver_i;
          exp_d  = TW'(expire_time_i);
          now_d  = TW'(current_time_i);
          fire_d = 1'b0;
          st_d   = (req_e'(req_type_i) == REQ_TICK) ? ST_NONE : ST_DONE;
          sre    = 1'b1;
          sraddr = SAW'(socket_id_i);
        end
      end
      S_SEXEC: begin
        if (in_rng) begin
          swe    = 1'b1;
          swdata = (req_q == REQ_REGISTER) ? {1'b1, EventBits'(0)}
                                           : {1'b0, srd[EventBits-1:0]};
        end
      end
      S_ACHK: begin
        if (!in_rng || !srd[SW-1]) begin
          st_d = ST_REJECT;
        end else if (cnt_q == (HAW+1)'(QUEUE_DEPTH)) begin
          st_d = ST_FULL;
        end else begin
          swe    = 1'b1;
          swdata = {1'b1, ev_q};
          cur_d  = {exp_q, sock_q, ev_q};
          idx_d  = HAW'(cnt_q);
          cnt_d  = cnt_q + (HAW+1)'(1);
        end
      end
      S_URD: begin
        if (idx_q == '0) begin
          hwe = 1'b1;
        end else begin
          hre    = 1'b1;
          hraddr = parent;
        end
      end
      S_UCMP: begin
        hwe = 1'b1;
        if (up_less) begin
          hwdata = hrd;
          idx_d  = parent;
        end
      end
      S_TTOP: begin
        if (cnt_q != '0) hre = 1'b1;
      end
      S_TCHK: begin
        if (!late) begin
          top_d  = hrd;
          cnt_d  = cnt_q - (HAW+1)'(1);
          hre    = 1'b1;
          hraddr = HAW'(cnt_q - (HAW+1)'(1));
          sre    = 1'b1;
          sraddr = SAW'(hrd[EventBits +: SockBits]);
        end
      end
      S_TLAST: begin
        cur_d = hrd;
        idx_d = '0;
        if (top_rng && srd[SW-1] && srd[EventBits-1:0] == top_q[EventBits-1:0]) begin
          fire_d = 1'b1;
          st_d   = ST_FIRED;
        end
      end
      S_DL: begin
        if (l_ok) begin
          hre    = 1'b1;
          hraddr = HAW'(lpos);
        end else begin
          hwe = 1'b1;
        end
      end
      S_DR: begin
        lval_d = hrd;
        rok_d  = r_ok;
        if (r_ok) begin
          hre    = 1'b1;
          hraddr = HAW'(rpos);
        end
      end
      S_DCMP: begin
        hwe = 1'b1;
        if (pick_r) begin
          hwdata = hrd;
          idx_d  = HAW'(rpos);
        end else if (pick_l) begin
          hwdata = lval_q;
          idx_d  = HAW'(lpos);
        end
      end
      S_TNEXT: ;
      S_FIN: begin
        if (out_free) begin
          ov_d    = 1'b1;
          ost_d   = st_q;
          osock_d = (st_q == ST_FIRED) ? top_q[EventBits +: SockBits] : '0;
          oev_d   = (st_q == ST_FIRED) ? top_q[EventBits-1:0] : '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      clr_q   <= '0;
      cnt_q   <= '0;
      ov_q    <= 1'b0;
      fire_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      cnt_q   <= cnt_d;
      ov_q    <= ov_d;
      fire_q  <= fire_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q   <= req_d;
    st_q    <= st_d;
    sock_q  <= sock_d;
    ev_q    <= ev_d;
    exp_q   <= exp_d;
    now_q   <= now_d;
    cur_q   <= cur_d;
    top_q   <= top_d;
    lval_q  <= lval_d;
    idx_q   <= idx_d;
    rok_q   <= rok_d;
    ost_q   <= ost_d;
    osock_q <= osock_d;
    oev_q   <= oev_d;
  end

  assign out_valid_o    = ov_q;
  assign status_o       = ost_q;
  assign fired_socket_o = osock_q;
  assign fired_event_o  = oev_q;

endmodule
`default_nettype wire

[rtl/tlc_checker.sv]
`default_nettype none
module tlc_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_stall_o,
  input wire logic [1:0]  req_type_i,
  input wire logic [5:0]  socket_id_i,
  input wire logic [31:0] event_ver_i,
  input wire logic [31:0] expire_time_i,
  input wire logic [31:0] current_time_i,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [2:0]  status_o,
  input wire logic [5:0]  fired_socket_o,
  input wire logic [31:0] fired_event_o
);
  import tlc_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped under stall");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(status_o) && $stable(fired_event_o))
    else $error("stalled result changed");

  a_fired_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_FIRED |-> fired_socket_o == '0 && fired_event_o == '0)
    else $error("fired fields set without a fired timer");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second transaction taken while busy");

endmodule

bind timer_heap_lazy_cancel tlc_checker u_tlc_checker (.*);
`default_nettype wire
